[hdl/srts_pkg.sv]
package srts_pkg;

    localparam int ID_W     = 8;
    localparam int BURST_W  = 16;
    localparam int OTIME_W  = 16;
    localparam int STATUS_W = 3;

    localparam int DEF_SLOTS     = 16;
    localparam int DEF_TIME_BITS = 16;
    localparam int DEF_ID_BITS   = 8;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RAN      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd4;

    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

endpackage

[hdl/shortest_remaining_time_scheduler.sv]
// shortest remaining time first job scheduler
//
// input channel (i_valid / o_ready): one request per transaction. i_req_type
// selects an arrival (i_job_id, i_burst_time) or one time tick.
// output channel (o_valid / i_ready): exactly one result per request, in
// order: status, job id, turnaround and waiting time on completion, and the
// tick count after the request.
//
// each request passes from acceptance through the scan of the slot table and
// a final step into the result register. the slot table sits in a single-port
// memory and one comparator walks it one slot per cycle, so a new request is
// taken only after the previous walk is done.
//
// a finished result waits in the output register while the next request is
// taken; if the receiver stalls, the block holds in its final step until the
// output register frees up, and o_ready stays low meanwhile.
// reset empties the table and clears the tick count; no clearing pass.
module shortest_remaining_time_scheduler #(
    parameter int SLOTS     = srts_pkg::DEF_SLOTS,
    parameter int TIME_BITS = srts_pkg::DEF_TIME_BITS,
    parameter int ID_BITS   = srts_pkg::DEF_ID_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_req_type,
    input  logic [srts_pkg::ID_W-1:0]      i_job_id,
    input  logic [srts_pkg::BURST_W-1:0]   i_burst_time,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [srts_pkg::STATUS_W-1:0]  o_status,
    output logic [srts_pkg::ID_W-1:0]      o_run_job,
    output logic [srts_pkg::OTIME_W-1:0]   o_turnaround,
    output logic [srts_pkg::OTIME_W-1:0]   o_waiting,
    output logic [srts_pkg::OTIME_W-1:0]   o_time_now
);
    import srts_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(SLOTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [ID_BITS-1:0]   mem_job [SLOTS];
    logic [BURST_W-1:0]   mem_rem [SLOTS];
    logic [BURST_W-1:0]   mem_burst [SLOTS];
    logic [TIME_BITS-1:0] mem_arr [SLOTS];

    logic [1:0]           r_state;
    logic [SLOTS-1:0]     r_valid;
    logic [TIME_BITS-1:0] r_tick;
    logic [CNT_W-1:0]     r_idx;
    logic                 r_rd_live;
    logic [SLOT_W-1:0]    r_rd_slot;
    logic [ID_BITS-1:0]   r_rd_job;
    logic [BURST_W-1:0]   r_rd_rem;
    logic [BURST_W-1:0]   r_rd_burst;
    logic [TIME_BITS-1:0] r_rd_arr;
    logic                 r_best_vld;
    logic [SLOT_W-1:0]    r_best_slot;
    logic [ID_BITS-1:0]   r_best_job;
    logic [BURST_W-1:0]   r_best_rem;
    logic [BURST_W-1:0]   r_best_burst;
    logic [TIME_BITS-1:0] r_best_arr;
    logic                 r_free_vld;
    logic [SLOT_W-1:0]    r_free_slot;
    logic                 r_req;
    logic [ID_W-1:0]      r_id;
    logic [BURST_W-1:0]   r_burst;
    logic                 r_out_valid;

    logic                 n_accept;
    logic                 n_scan_rd;
    logic [SLOT_W-1:0]    n_scan_slot;
    logic                 n_better;
    logic                 n_fin;
    logic                 n_reject;
    logic                 n_arr_wr;
    logic                 n_tick_wr;
    logic                 n_done;
    logic [TIME_BITS-1:0] n_tick;
    logic [BURST_W-1:0]   n_rem;
    logic [TIME_BITS-1:0] n_tat;
    logic [TIME_BITS-1:0] n_wait;
    logic [31:0]          n_tat_ext;
    logic [31:0]          n_wait_ext;
    logic [31:0]          n_time_ext;
    logic [15:0]          n_job_ext;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign n_accept = i_valid && o_ready;

    assign n_scan_rd   = (r_state == S_SCAN) && (r_idx != SCAN_END);
    assign n_scan_slot = r_idx[SLOT_W-1:0];
    assign n_better    = r_rd_live && (!r_best_vld || (r_rd_rem < r_best_rem));

    assign n_fin     = (r_state == S_FIN) && (!r_out_valid || i_ready);
    assign n_reject  = (r_burst == '0) || !r_free_vld;
    assign n_arr_wr  = n_fin && (r_req == REQ_ARRIVE) && !n_reject;
    assign n_tick_wr = n_fin && (r_req == REQ_TICK) && r_best_vld;

    assign n_tick = r_tick + TIME_BITS'(1);
    assign n_rem  = r_best_rem - BURST_W'(1);
    assign n_done = (n_rem == '0);
    assign n_tat  = n_tick - r_best_arr;
    assign n_wait = n_tat - TIME_BITS'(r_best_burst);

    assign n_tat_ext  = 32'(n_tat);
    assign n_wait_ext = 32'(n_wait);
    assign n_job_ext  = 16'(r_best_job);
    assign n_time_ext = (r_req == REQ_TICK) ? 32'(n_tick) : 32'(r_tick);

    // slot table
    always_ff @(posedge i_clk) begin
        if (n_scan_rd) begin
            r_rd_job   <= mem_job[n_scan_slot];
            r_rd_rem   <= mem_rem[n_scan_slot];
            r_rd_burst <= mem_burst[n_scan_slot];
            r_rd_arr   <= mem_arr[n_scan_slot];
        end
        if (n_arr_wr) begin
            mem_job[r_free_slot]   <= ID_BITS'(r_id);
            mem_rem[r_free_slot]   <= r_burst;
            mem_burst[r_free_slot] <= r_burst;
            mem_arr[r_free_slot]   <= r_tick;
        end else if (n_tick_wr) begin
            mem_rem[r_best_slot] <= n_rem;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_req   <= i_req_type;
            r_id    <= i_job_id;
            r_burst <= i_burst_time;
        end
        if (n_scan_rd) begin
            r_rd_slot <= n_scan_slot;
        end
        if (n_scan_rd && !r_free_vld && !r_valid[n_scan_slot]) begin
            r_free_slot <= n_scan_slot;
        end
        if ((r_state == S_SCAN) && n_better) begin
            r_best_slot  <= r_rd_slot;
            r_best_job   <= r_rd_job;
            r_best_rem   <= r_rd_rem;
            r_best_burst <= r_rd_burst;
            r_best_arr   <= r_rd_arr;
        end
        if (n_fin) begin
            o_time_now <= n_time_ext[OTIME_W-1:0];
            if (r_req == REQ_ARRIVE) begin
                o_status     <= n_reject ? ST_REJECTED : ST_ACCEPTED;
                o_run_job    <= r_id;
                o_turnaround <= '0;
                o_waiting    <= '0;
            end else if (!r_best_vld) begin
                o_status     <= ST_IDLE;
                o_run_job    <= '0;
                o_turnaround <= '0;
                o_waiting    <= '0;
            end else begin
                o_run_job <= n_job_ext[ID_W-1:0];
                if (n_done) begin
                    o_status     <= ST_FINISHED;
                    o_turnaround <= n_tat_ext[OTIME_W-1:0];
                    o_waiting    <= n_wait_ext[OTIME_W-1:0];
                end else begin
                    o_status     <= ST_RAN;
                    o_turnaround <= '0;
                    o_waiting    <= '0;
                end
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_tick      <= '0;
            r_idx       <= '0;
            r_rd_live   <= 1'b0;
            r_best_vld  <= 1'b0;
            r_free_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !n_fin) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_state    <= S_SCAN;
                        r_idx      <= '0;
                        r_rd_live  <= 1'b0;
                        r_best_vld <= 1'b0;
                        r_free_vld <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (n_better) begin
                        r_best_vld <= 1'b1;
                    end
                    if (n_scan_rd) begin
                        r_rd_live <= r_valid[n_scan_slot];
                        r_idx     <= r_idx + CNT_W'(1);
                        if (!r_valid[n_scan_slot]) begin
                            r_free_vld <= 1'b1;
                        end
                    end else begin
                        r_rd_live <= 1'b0;
                        r_state   <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (n_fin) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_req == REQ_TICK) begin
                            r_tick <= n_tick;
                        end
                        if (n_arr_wr) begin
                            r_valid[r_free_slot] <= 1'b1;
                        end
                        if (n_tick_wr && n_done) begin
                            r_valid[r_best_slot] <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[tb/sv/srts_result_checker.sv]
`timescale 1ns / 1ps

module srts_result_checker
    import srts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic                  i_req_type,
    input  logic [ID_W-1:0]       i_job_id,
    input  logic [BURST_W-1:0]    i_burst_time,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [STATUS_W-1:0]   i_status,
    input  logic [ID_W-1:0]       i_run_job,
    input  logic [OTIME_W-1:0]    i_turnaround,
    input  logic [OTIME_W-1:0]    i_waiting,
    input  logic [OTIME_W-1:0]    i_time_now,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_n_accept,
    output int                    o_n_reject,
    output int                    o_n_idle,
    output int                    o_n_ran,
    output int                    o_n_done,
    output int                    o_n_wraps
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     job;
        logic [OTIME_W-1:0]  turnaround;
        logic [OTIME_W-1:0]  waiting;
        logic [OTIME_W-1:0]  time_now;
    } sched_result_t;

    logic                 slot_used      [DEF_SLOTS];
    logic [ID_W-1:0]      slot_job       [DEF_SLOTS];
    logic [BURST_W-1:0]   slot_left      [DEF_SLOTS];
    logic [BURST_W-1:0]   slot_burst     [DEF_SLOTS];
    logic [OTIME_W-1:0]   slot_arrival   [DEF_SLOTS];
    logic [OTIME_W-1:0]   tick_now;

    sched_result_t expected_results[$];
    int            mismatches = 0;
    int            n_checked  = 0;
    int            status_seen[5] = '{0, 0, 0, 0, 0};
    int            n_wraps    = 0;

    assign o_errors   = mismatches;
    assign o_n_accept = status_seen[ST_ACCEPTED];
    assign o_n_reject = status_seen[ST_REJECTED];
    assign o_n_idle   = status_seen[ST_IDLE];
    assign o_n_ran    = status_seen[ST_RAN];
    assign o_n_done   = status_seen[ST_FINISHED];
    assign o_n_wraps  = n_wraps;

    task automatic report_mismatch(input string msg);
        if (mismatches < 25) begin
            $display("t=%0t mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic schedule_step(input logic req, input logic [ID_W-1:0] id,
                                 input logic [BURST_W-1:0] burst,
                                 output sched_result_t res);
        int free_slot;
        int pick;
        res = '0;
        res.job = id;
        if (req == REQ_ARRIVE) begin
            free_slot = -1;
            for (int s = 0; s < DEF_SLOTS; s++) begin
                if (free_slot < 0 && !slot_used[s]) begin
                    free_slot = s;
                end
            end
            if (burst == '0 || free_slot < 0) begin
                res.status = ST_REJECTED;
            end else begin
                slot_used[free_slot]    = 1'b1;
                slot_job[free_slot]     = id;
                slot_left[free_slot]    = burst;
                slot_burst[free_slot]   = burst;
                slot_arrival[free_slot] = tick_now;
                res.status = ST_ACCEPTED;
            end
        end else begin
            pick = -1;
            for (int s = 0; s < DEF_SLOTS; s++) begin
                if (slot_used[s] && (pick < 0 || slot_left[s] < slot_left[pick])) begin
                    pick = s;
                end
            end
            tick_now = tick_now + 1'b1;
            if (tick_now == '0) begin
                n_wraps++;
            end
            if (pick < 0) begin
                res.status = ST_IDLE;
                res.job    = '0;
            end else begin
                slot_left[pick] = slot_left[pick] - 1'b1;
                res.job = slot_job[pick];
                if (slot_left[pick] == '0) begin
                    res.status     = ST_FINISHED;
                    res.turnaround = tick_now - slot_arrival[pick];
                    res.waiting    = res.turnaround - slot_burst[pick];
                    slot_used[pick] = 1'b0;
                end else begin
                    res.status = ST_RAN;
                end
            end
        end
        res.time_now = tick_now;
    endtask

    always @(posedge i_clk) begin : watch
        sched_result_t want;
        sched_result_t got;
        if (!i_rst_n) begin
            for (int s = 0; s < DEF_SLOTS; s++) begin
                slot_used[s] = 1'b0;
            end
            tick_now = '0;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = '{i_status, i_run_job, i_turnaround, i_waiting, i_time_now};
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected: status %0d job %0d",
                                              got.status, got.job));
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                                  n_checked, got.status, want.status));
                    if (got.job != want.job)
                        report_mismatch($sformatf("result %0d run_job %0d, expected %0d",
                                                  n_checked, got.job, want.job));
                    if (got.turnaround != want.turnaround)
                        report_mismatch($sformatf("result %0d turnaround %0d, expected %0d",
                                                  n_checked, got.turnaround, want.turnaround));
                    if (got.waiting != want.waiting)
                        report_mismatch($sformatf("result %0d waiting %0d, expected %0d",
                                                  n_checked, got.waiting, want.waiting));
                    if (got.time_now != want.time_now)
                        report_mismatch($sformatf("result %0d time_now %0d, expected %0d",
                                                  n_checked, got.time_now, want.time_now));
                end
                n_checked++;
            end
            if (i_req_valid && i_req_ready) begin
                schedule_step(i_req_type, i_job_id, i_burst_time, want);
                expected_results.insert(expected_results.size(), want);
                status_seen[want.status]++;
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

[tb/sv/tb_shortest_remaining_time_scheduler.sv]
`timescale 1ns / 1ps

module tb_shortest_remaining_time_scheduler;
    import srts_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 800;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_req_type;
    logic [ID_W-1:0]      i_job_id;
    logic [BURST_W-1:0]   i_burst_time;
    logic                 o_valid;
    logic                 i_ready;
    logic [STATUS_W-1:0]  o_status;
    logic [ID_W-1:0]      o_run_job;
    logic [OTIME_W-1:0]   o_turnaround;
    logic [OTIME_W-1:0]   o_waiting;
    logic [OTIME_W-1:0]   o_time_now;

    int errors;
    int pending;
    int n_accept;
    int n_reject;
    int n_idle;
    int n_ran;
    int n_done;
    int n_wraps;

    bit hold_rx_req = 1'b0;
    bit rx_free_run = 1'b0;

    shortest_remaining_time_scheduler DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_job_id     (i_job_id),
        .i_burst_time (i_burst_time),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_run_job    (o_run_job),
        .o_turnaround (o_turnaround),
        .o_waiting    (o_waiting),
        .o_time_now   (o_time_now)
    );

    srts_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_req_type   (i_req_type),
        .i_job_id     (i_job_id),
        .i_burst_time (i_burst_time),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_status     (o_status),
        .i_run_job    (o_run_job),
        .i_turnaround (o_turnaround),
        .i_waiting    (o_waiting),
        .i_time_now   (o_time_now),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_n_accept   (n_accept),
        .o_n_reject   (n_reject),
        .o_n_idle     (n_idle),
        .o_n_ran      (n_ran),
        .o_n_done     (n_done),
        .o_n_wraps    (n_wraps)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // one transaction on the request side, optionally after a random gap
    task automatic send_req(input logic req, input logic [ID_W-1:0] id,
                            input logic [BURST_W-1:0] burst, input bit no_gap);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gap || roll < 50) gap = 0;
        else if (roll < 90) gap = $urandom_range(1, 3);
        else if (roll < 97) gap = $urandom_range(4, 12);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_job_id     <= id;
        i_burst_time <= burst;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // receiver: random stalls, one long hold-off on request, free run on request
    initial begin : receiver
        int on_len;
        int off_len;
        i_ready <= 1'b0;
        forever begin
            if (hold_rx_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx_req = 1'b0;
            end else if (rx_free_run) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                on_len  = $urandom_range(1, 20);
                off_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 3);
                i_ready <= 1'b1;
                repeat (on_len) @(posedge i_clk);
                if (!rx_free_run) begin
                    i_ready <= 1'b0;
                    repeat (off_len) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) quiet = 0;
            else quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("watchdog: %0d cycles without a transaction", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int arrive_pct;
        int roll;
        int sel;
        logic [BURST_W-1:0] burst;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_req_type   <= REQ_ARRIVE;
        i_job_id     <= '0;
        i_burst_time <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table tick, zero burst, longest job, ties, arrival before tick
        send_req(REQ_TICK, 8'h00, 16'h0000, 1'b0);
        send_req(REQ_ARRIVE, 8'h00, 16'h0000, 1'b0);
        send_req(REQ_ARRIVE, 8'hFF, 16'hFFFF, 1'b0);
        send_req(REQ_ARRIVE, 8'h5A, 16'd3, 1'b0);
        send_req(REQ_ARRIVE, 8'hA5, 16'd3, 1'b0);
        send_req(REQ_TICK, 8'hFF, 16'hFFFF, 1'b0);
        send_req(REQ_ARRIVE, 8'h5A, 16'd1, 1'b0);
        send_req(REQ_TICK, 8'h00, 16'h0000, 1'b0);
        for (int k = 0; k < 13; k++) begin
            send_req(REQ_ARRIVE, 8'(8'h10 + k), 16'(2 + k % 4), 1'b0);
        end
        // table full
        send_req(REQ_ARRIVE, 8'h77, 16'h8000, 1'b0);

        // run the short jobs off, the long job stays behind
        rx_free_run = 1'b1;
        for (int k = 0; k < 60; k++) begin
            send_req(REQ_TICK, 8'($urandom_range(0, 255)),
                     16'($urandom_range(0, 65535)), 1'b1);
        end
        rx_free_run = 1'b0;

        arrive_pct = 45;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: arrive_pct = 75;
                    1: arrive_pct = 20;
                    default: arrive_pct = 45;
                endcase
            end
            if (n == 200) hold_rx_req = 1'b1;
            if (n == 500) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < arrive_pct) begin
                sel = $urandom_range(0, 99);
                if (sel < 4) burst = '0;
                else if (sel < 5) burst = 16'($urandom_range(1, 65535));
                else burst = 16'($urandom_range(1, 12));
                send_req(REQ_ARRIVE, 8'($urandom_range(0, 255)), burst, 1'b0);
            end else begin
                send_req(REQ_TICK, 8'($urandom_range(0, 255)),
                         16'($urandom_range(0, 65535)), 1'b0);
            end
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);

        $display("covered %0d requests: %0d jobs admitted, %0d arrivals turned away",
                 n_accept + n_reject + n_idle + n_ran + n_done, n_accept, n_reject);
        $display("%0d idle ticks, %0d ticks run, %0d jobs completed, %0d counter wraps",
                 n_idle, n_ran, n_done, n_wraps);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[files.f]
hdl/srts_pkg.sv
hdl/shortest_remaining_time_scheduler.sv
tb/sv/srts_result_checker.sv
tb/sv/tb_shortest_remaining_time_scheduler.sv
